// ===== src/i2cbr_pkg.sv =====
// shared types and constants for the i2c bus recovery sequencer
`default_nettype none

package i2cbr_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_TIME    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_TIME   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCL_TIMEOUT = 2'd3;

  localparam logic [7:0]  DEF_PULSE_LIMIT = 8'd16;
  localparam logic [15:0] DEF_LOW_TIME    = 16'd10;
  localparam logic [15:0] DEF_HIGH_TIME   = 16'd10;
  localparam logic [15:0] DEF_SCL_TIMEOUT = 16'd100;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SCL  = 2'd1,
    ST_SDA  = 2'd2,
    ST_STOP = 2'd3
  } status_t;

  localparam int unsigned DRV_SCL = 0;
  localparam int unsigned DRV_SDA = 1;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_START = 1'b1
  } op_t;

  typedef struct packed {
    logic op;
    logic scl_level;
    logic sda_level;
  } in_item_t;

  typedef struct packed {
    logic       scl_pull_low;
    logic       sda_pull_low;
    logic       busy_res;
    logic       finished;
    logic [1:0] status;
    logic [7:0] pulses_used;
  } out_item_t;

endpackage

`default_nettype wire

// ===== src/i2cbr_in_if.sv =====
// valid/ready channel carrying one input item
`default_nettype none

interface i2cbr_in_if
  import i2cbr_pkg::*;
;
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== src/i2cbr_out_if.sv =====
// valid/ready channel carrying one result item
`default_nettype none

interface i2cbr_out_if
  import i2cbr_pkg::*;
;
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== src/i2c_bus_recovery_sequencer_top.sv =====
// i2c bus-clear recovery sequencer: one result item per accepted item
// the result is registered and valid the cycle after the item is accepted
// one item per cycle while out_if is ready; state update is a single register stage
// output register frees itself when taken, so input stays ready under a taken result
// rst_n is synchronous, active low; clears phase, counters, line drive, status and config
`default_nettype none

module i2c_bus_recovery_sequencer_top
  import i2cbr_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  i2cbr_in_if.sink                   in_if,
  i2cbr_out_if.source                out_if,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_SETTLE = 4'd1,
    PH_WAIT0  = 4'd2,
    PH_PLOW   = 4'd3,
    PH_PWAIT  = 4'd4,
    PH_PHIGH  = 4'd5,
    PH_CHECK  = 4'd6,
    PH_SLOW   = 4'd7,
    PH_SWAIT  = 4'd8,
    PH_SHIGH  = 4'd9,
    PH_SREL   = 4'd10,
    PH_SREAD  = 4'd11
  } phase_t;

  logic [7:0]  pulse_limit_r;
  logic [15:0] low_time_r;
  logic [15:0] high_time_r;
  logic [15:0] scl_timeout_r;

  phase_t      phase_r, phase_nxt;
  logic [15:0] delay_r, delay_nxt;
  logic [15:0] wait_r, wait_nxt;
  logic [7:0]  pulse_r, pulse_nxt;
  status_t     status_r, status_nxt;
  logic [1:0]  drive_r, drive_nxt;

  logic        out_valid_r;
  out_item_t   out_data_r;

  logic [7:0]  eff_pulses;
  logic [15:0] eff_low, eff_high, eff_timeout;
  logic [15:0] wait_inc, delay_dec;
  logic        wait_hit, delay_end;
  logic        fin, chk, done;
  status_t     fin_st;
  logic        in_fire;

  assign eff_pulses  = (pulse_limit_r != 8'd0) ? pulse_limit_r : DEF_PULSE_LIMIT;
  assign eff_low     = (low_time_r != 16'd0) ? low_time_r : DEF_LOW_TIME;
  assign eff_high    = (high_time_r != 16'd0) ? high_time_r : DEF_HIGH_TIME;
  assign eff_timeout = (scl_timeout_r != 16'd0) ? scl_timeout_r : DEF_SCL_TIMEOUT;

  assign in_if.ready  = !out_valid_r || out_if.ready;
  assign in_fire      = in_if.valid && in_if.ready;
  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_data_r;

  assign wait_inc  = wait_r + 16'd1;
  assign wait_hit  = !in_if.data.scl_level && (wait_inc >= eff_timeout);
  assign delay_dec = (delay_r != 16'd0) ? delay_r - 16'd1 : 16'd0;
  assign delay_end = (delay_dec == 16'd0);

  always_comb begin
    phase_nxt  = phase_r;
    delay_nxt  = delay_r;
    wait_nxt   = wait_r;
    pulse_nxt  = pulse_r;
    status_nxt = status_r;
    drive_nxt  = drive_r;
    fin        = 1'b0;
    fin_st     = ST_OK;
    chk        = 1'b0;
    done       = 1'b0;
    unique case (phase_r)
      PH_IDLE: begin
        if (in_if.data.op == OP_START) begin
          drive_nxt = 2'b00;
          pulse_nxt = 8'd0;
          wait_nxt  = 16'd0;
          phase_nxt = PH_SETTLE;
          delay_nxt = eff_high;
        end
      end
      PH_SETTLE: begin
        delay_nxt = delay_dec;
        if (delay_end) begin
          wait_nxt  = 16'd0;
          phase_nxt = PH_WAIT0;
        end
      end
      PH_WAIT0: begin
        if (in_if.data.scl_level) begin
          chk = 1'b1;
        end else begin
          wait_nxt = wait_inc;
          fin      = wait_hit;
          fin_st   = ST_SCL;
        end
      end
      PH_PLOW, PH_SLOW: begin
        delay_nxt = delay_dec;
        if (delay_end) begin
          drive_nxt[DRV_SCL] = 1'b0;
          wait_nxt           = 16'd0;
          phase_nxt          = (phase_r == PH_PLOW) ? PH_PWAIT : PH_SWAIT;
        end
      end
      PH_PWAIT, PH_SWAIT: begin
        if (in_if.data.scl_level) begin
          phase_nxt = (phase_r == PH_PWAIT) ? PH_PHIGH : PH_SHIGH;
          delay_nxt = eff_high;
        end else begin
          wait_nxt = wait_inc;
          fin      = wait_hit;
          fin_st   = (phase_r == PH_PWAIT) ? ST_SCL : ST_STOP;
        end
      end
      PH_PHIGH: begin
        delay_nxt = delay_dec;
        if (delay_end) begin
          pulse_nxt = pulse_r + 8'd1;
          phase_nxt = PH_CHECK;
        end
      end
      PH_CHECK: begin
        chk = 1'b1;
      end
      PH_SHIGH: begin
        delay_nxt = delay_dec;
        if (delay_end) begin
          drive_nxt[DRV_SDA] = 1'b0;
          phase_nxt          = PH_SREL;
          delay_nxt          = eff_high;
        end
      end
      PH_SREL: begin
        delay_nxt = delay_dec;
        if (delay_end) begin
          phase_nxt = PH_SREAD;
        end
      end
      PH_SREAD: begin
        fin    = 1'b1;
        fin_st = in_if.data.sda_level ? ST_OK : ST_STOP;
      end
      default: begin
        fin    = 1'b1;
        fin_st = ST_OK;
      end
    endcase

    if (chk) begin
      if (!in_if.data.sda_level) begin
        if (pulse_r < eff_pulses) begin
          drive_nxt[DRV_SCL] = 1'b1;
          phase_nxt          = PH_PLOW;
          delay_nxt          = eff_low;
        end else begin
          fin    = 1'b1;
          fin_st = ST_SDA;
        end
      end else begin
        drive_nxt[DRV_SDA] = 1'b1;
        phase_nxt          = PH_SLOW;
        delay_nxt          = eff_low;
      end
    end

    if (fin) begin
      status_nxt = fin_st;
      drive_nxt  = 2'b00;
      phase_nxt  = PH_IDLE;
      delay_nxt  = 16'd0;
      wait_nxt   = 16'd0;
      done       = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_limit_r <= 8'd0;
      low_time_r    <= 16'd0;
      high_time_r   <= 16'd0;
      scl_timeout_r <= 16'd0;
      phase_r       <= PH_IDLE;
      delay_r       <= 16'd0;
      wait_r        <= 16'd0;
      pulse_r       <= 8'd0;
      status_r      <= ST_OK;
      drive_r       <= 2'b00;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_PULSE_LIMIT: pulse_limit_r <= cfg_data[7:0];
          CFG_LOW_TIME:    low_time_r    <= cfg_data;
          CFG_HIGH_TIME:   high_time_r   <= cfg_data;
          CFG_SCL_TIMEOUT: scl_timeout_r <= cfg_data;
          default: ;
        endcase
      end
      if (in_fire) begin
        phase_r     <= phase_nxt;
        delay_r     <= delay_nxt;
        wait_r      <= wait_nxt;
        pulse_r     <= pulse_nxt;
        status_r    <= status_nxt;
        drive_r     <= drive_nxt;
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r.scl_pull_low <= drive_nxt[DRV_SCL];
      out_data_r.sda_pull_low <= drive_nxt[DRV_SDA];
      out_data_r.busy_res     <= (phase_nxt != PH_IDLE);
      out_data_r.finished     <= done;
      out_data_r.status       <= status_nxt;
      out_data_r.pulses_used  <= pulse_nxt;
    end
  end

  a_idle_released: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) |-> (drive_r == 2'b00))
    else $error("lines driven while idle");

  a_delay_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_SETTLE || phase_r == PH_PLOW || phase_r == PH_PHIGH ||
     phase_r == PH_SLOW || phase_r == PH_SHIGH || phase_r == PH_SREL)
    |-> (delay_r != 16'd0))
    else $error("delay phase with empty delay counter");

  a_finish_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.finished)
    |-> (!out_data_r.busy_res && !out_data_r.scl_pull_low && !out_data_r.sda_pull_low))
    else $error("finished item reports busy or driven lines");

  a_idle_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && phase_r == PH_IDLE && in_if.data.op == OP_TICK)
    |=> (out_valid_r && !out_data_r.busy_res && !out_data_r.finished))
    else $error("tick while idle changed the sequence");

endmodule

`default_nettype wire
